>>> src/sssp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Smoothstep speed profile package
// Shared widths, codes, register layout and types of the speed profile block.
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int X_FRAC_BITS = 16;

    localparam int SPD_W  = 24;
    localparam int DUR_W  = 16;
    localparam int TIME_W = 32;
    localparam int TRIG_W = 31;
    localparam int PROG_W = 32;

    // serial multiplier operand widths
    localparam int P_W  = X_FRAC_BITS + 4;
    localparam int MC_W = (SPD_W > P_W) ? SPD_W : P_W;
    localparam int MP_W = X_FRAC_BITS + 1;
    localparam int PR_W = MC_W + MP_W;

    localparam int DIV_CNT_W = $clog2(X_FRAC_BITS + 1);
    localparam int MUL_CNT_W = $clog2(MP_W + 1);

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 32;

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_START_SPEED  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CRUISE_SPEED = 3'd1;
    localparam logic [IDX_W-1:0] REG_ACCEL_TIME   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DECEL_TRIG   = 3'd3;
    localparam logic [IDX_W-1:0] REG_FINISH_SPEED = 3'd4;
    localparam logic [IDX_W-1:0] REG_DECEL_TIME   = 3'd5;

    localparam logic [SPD_W-1:0]  RST_START_SPEED  = 24'd128000;
    localparam logic [SPD_W-1:0]  RST_CRUISE_SPEED = 24'd819200;
    localparam logic [DUR_W-1:0]  RST_ACCEL_TIME   = 16'd3000;
    localparam logic [TRIG_W-1:0] RST_DECEL_TRIG   = 31'd18000;
    localparam logic [SPD_W-1:0]  RST_FINISH_SPEED = 24'd179200;
    localparam logic [DUR_W-1:0]  RST_DECEL_TIME   = 16'd2400;

    localparam logic [1:0] MODE_HOLD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;
    localparam logic [1:0] MODE_OFF  = 2'd3;

    localparam logic [1:0] STAGE_IDLE     = 2'd0;
    localparam logic [1:0] STAGE_RAMP     = 2'd1;
    localparam logic [1:0] STAGE_CRUISE   = 2'd2;
    localparam logic [1:0] STAGE_STOPPING = 2'd3;

    typedef struct packed {
        logic [SPD_W-1:0]  start_speed;
        logic [SPD_W-1:0]  cruise_speed;
        logic [DUR_W-1:0]  accel_time_ms;
        logic [TRIG_W-1:0] decel_trigger_count;
        logic [SPD_W-1:0]  finish_speed;
        logic [DUR_W-1:0]  decel_time_ms;
    } cfg_t;

    // one curve evaluation; elapsed is already known to be below duration
    typedef struct packed {
        logic [SPD_W-1:0] a;
        logic [SPD_W-1:0] b;
        logic [DUR_W-1:0] e;
        logic [DUR_W-1:0] d;
    } curve_req_t;

endpackage
`default_nettype wire

>>> src/sssp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Speed profile configuration registers
// APB register file holding the speeds, curve durations and trigger count.
// ----------------------------------------------------------------------------
module sssp_cfg
    import sssp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_speed         <= RST_START_SPEED;
            cfg_reg.cruise_speed        <= RST_CRUISE_SPEED;
            cfg_reg.accel_time_ms       <= RST_ACCEL_TIME;
            cfg_reg.decel_trigger_count <= RST_DECEL_TRIG;
            cfg_reg.finish_speed        <= RST_FINISH_SPEED;
            cfg_reg.decel_time_ms       <= RST_DECEL_TIME;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_START_SPEED:  cfg_reg.start_speed         <= pwdata[SPD_W-1:0];
                REG_CRUISE_SPEED: cfg_reg.cruise_speed        <= pwdata[SPD_W-1:0];
                REG_ACCEL_TIME:   cfg_reg.accel_time_ms       <= pwdata[DUR_W-1:0];
                REG_DECEL_TRIG:   cfg_reg.decel_trigger_count <= pwdata[TRIG_W-1:0];
                REG_FINISH_SPEED: cfg_reg.finish_speed        <= pwdata[SPD_W-1:0];
                REG_DECEL_TIME:   cfg_reg.decel_time_ms       <= pwdata[DUR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START_SPEED:  prdata = 32'(cfg_reg.start_speed);
            REG_CRUISE_SPEED: prdata = 32'(cfg_reg.cruise_speed);
            REG_ACCEL_TIME:   prdata = 32'(cfg_reg.accel_time_ms);
            REG_DECEL_TRIG:   prdata = 32'(cfg_reg.decel_trigger_count);
            REG_FINISH_SPEED: prdata = 32'(cfg_reg.finish_speed);
            REG_DECEL_TIME:   prdata = 32'(cfg_reg.decel_time_ms);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> src/sssp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Speed profile curve position divider
// Bit-serial restoring divider giving x = floor(e * 2^F / d) for e < d.
// ----------------------------------------------------------------------------
module sssp_div
    import sssp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [DUR_W-1:0]       dividend,
    input  wire logic [DUR_W-1:0]       divisor,
    output logic                        done,
    output logic      [X_FRAC_BITS-1:0] quotient
);

    logic [DUR_W-1:0]       rem_reg, rem_next;
    logic [DUR_W-1:0]       dvs_reg;
    logic [X_FRAC_BITS-1:0] quo_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [DUR_W:0]         trial;
    logic [DUR_W:0]         diff;
    logic                   ge;

    // remainder stays below the divisor, so twice it fits one extra bit
    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(X_FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[X_FRAC_BITS-2:0], ge};
        end
    end

endmodule
`default_nettype wire

>>> src/sssp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Speed profile serial multiplier
// Shift-and-add multiplier taking one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sssp_mul
    import sssp_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [MC_W-1:0] mcand,
    input  wire logic [MP_W-1:0] mplier,
    output logic                 done,
    output logic      [PR_W-1:0] product
);

    logic [PR_W-1:0]      acc_reg;
    logic [MC_W-1:0]      mcand_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MC_W-1:0]      addend;
    logic [MC_W:0]        sum;

    // low part of the accumulator holds the multiplier bits still to use
    assign addend = acc_reg[0] ? mcand_reg : '0;
    assign sum    = {1'b0, acc_reg[PR_W-1:MP_W]} + {1'b0, addend};

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == MUL_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MP_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= {{MC_W{1'b0}}, mplier};
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum, acc_reg[MP_W-1:1]};
        end
    end

endmodule
`default_nettype wire

>>> src/sssp_curve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Speed profile smootherstep curve
// Sequences the divider and the shared multiplier to evaluate
// a +/- (b - a) * (6x^5 - 15x^4 + 10x^3) in fixed point.
// ----------------------------------------------------------------------------
module sssp_curve
    import sssp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  curve_req_t            req,
    output logic                  done,
    output logic      [SPD_W-1:0] result
);

    typedef enum logic [5:0] {
        C_IDLE  = 6'b000001,
        C_DIV   = 6'b000010,
        C_SQ    = 6'b000100,
        C_CUBE  = 6'b001000,
        C_POLY  = 6'b010000,
        C_SCALE = 6'b100000
    } curve_state_t;

    curve_state_t           state_reg;
    logic [SPD_W-1:0]       a_reg;
    logic [SPD_W-1:0]       diff_reg;
    logic                   up_reg;
    logic [X_FRAC_BITS-1:0] x_reg;
    logic [X_FRAC_BITS-1:0] x2_reg;
    logic [SPD_W-1:0]       result_reg;
    logic                   done_reg;

    logic                   div_done;
    logic [X_FRAC_BITS-1:0] div_q;
    logic                   mul_start;
    logic [MC_W-1:0]        mul_mcand;
    logic [MP_W-1:0]        mul_mplier;
    logic                   mul_done;
    logic [PR_W-1:0]        mul_prod;

    logic [X_FRAC_BITS-1:0] prod_q;
    logic [MP_W-1:0]        prod_s;
    logic [SPD_W-1:0]       step;
    logic [P_W:0]           p_wide;
    logic [P_W-1:0]         p_val;

    assign prod_q = mul_prod[2*X_FRAC_BITS-1:X_FRAC_BITS];
    assign prod_s = mul_prod[2*X_FRAC_BITS:X_FRAC_BITS];
    assign step   = mul_prod[X_FRAC_BITS+SPD_W-1:X_FRAC_BITS];

    // p = 6*x2 - 15*x + 10, all scaled by 2^F; stays positive below x = 1
    assign p_wide = ((P_W+1)'(x2_reg) << 2) + ((P_W+1)'(x2_reg) << 1)
                  + ((P_W+1)'(10) << X_FRAC_BITS)
                  - (((P_W+1)'(x_reg) << 4) - (P_W+1)'(x_reg));
    assign p_val  = p_wide[P_W-1:0];

    assign done   = done_reg;
    assign result = result_reg;

    sssp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (req.e),
        .divisor  (req.d),
        .done     (div_done),
        .quotient (div_q)
    );

    sssp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_prod)
    );

    // launch the next product as soon as the previous unit finishes
    always_comb
    begin
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mplier = '0;
        unique case (state_reg)
            C_DIV:
            begin
                mul_start  = div_done;
                mul_mcand  = MC_W'(div_q);
                mul_mplier = MP_W'(div_q);
            end
            C_SQ:
            begin
                mul_start  = mul_done;
                mul_mcand  = MC_W'(prod_q);
                mul_mplier = MP_W'(x_reg);
            end
            C_CUBE:
            begin
                mul_start  = mul_done;
                mul_mcand  = MC_W'(p_val);
                mul_mplier = MP_W'(prod_q);
            end
            C_POLY:
            begin
                mul_start  = mul_done;
                mul_mcand  = MC_W'(diff_reg);
                mul_mplier = prod_s;
            end
            C_IDLE, C_SCALE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == C_SCALE) && mul_done;
            unique case (state_reg)
                C_IDLE:  if (start)    state_reg <= C_DIV;
                C_DIV:   if (div_done) state_reg <= C_SQ;
                C_SQ:    if (mul_done) state_reg <= C_CUBE;
                C_CUBE:  if (mul_done) state_reg <= C_POLY;
                C_POLY:  if (mul_done) state_reg <= C_SCALE;
                C_SCALE:
                begin
                    if (mul_done)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= req.a;
            up_reg   <= req.b >= req.a;
            diff_reg <= (req.b >= req.a) ? (req.b - req.a) : (req.a - req.b);
        end
        if (state_reg == C_DIV && div_done)
        begin
            x_reg <= div_q;
        end
        if (state_reg == C_SQ && mul_done)
        begin
            x2_reg <= prod_q;
        end
        // truncate the step toward the start value
        if (state_reg == C_SCALE && mul_done)
        begin
            result_reg <= up_reg ? (a_reg + step) : (a_reg - step);
        end
    end

endmodule
`default_nettype wire

>>> src/smoothstep_speed_profile_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Smoothstep speed profile
// Per control tick speed command following quintic smootherstep ramps.
// ----------------------------------------------------------------------------
// One input transfer per control tick yields exactly one output transfer with
// the new base speed and stage. Ticks that evaluate no curve (hold, stop, off,
// or a curve already past its duration) pass from input transfer through the
// decide state and the commit state, which waits for a free output, to output
// valid. A tick that evaluates a curve runs the bit-serial divider and then
// four products on the shared serial multiplier between those states. One item
// is worked on at a time, and a finished result is held until the output side
// takes it.
module smoothstep_speed_profile_top
    import sssp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // apb configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // now_ms[31:0], run_elapsed_ms[63:32], left_start[64], progress[96:65]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // mission_mode[1:0]
    input  wire logic [1:0]             s_tuser,
    // output stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // base_speed[23:0], stage[25:24]
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        T_IDLE   = 4'b0001,
        T_DECIDE = 4'b0010,
        T_CURVE  = 4'b0100,
        T_COMMIT = 4'b1000
    } top_state_t;

    cfg_t       cfg;
    top_state_t state_reg;

    logic [1:0]        mode_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] run_el_reg;
    logic              left_reg;
    logic [PROG_W-1:0] prog_reg;

    logic              dact_reg;
    logic [TIME_W-1:0] dstart_time_reg;
    logic [SPD_W-1:0]  dstart_speed_reg;
    logic [SPD_W-1:0]  speed_reg;
    logic [1:0]        stage_reg;
    logic              was_run_reg;
    logic              out_valid_reg;

    logic              accel_reg;
    logic              trig_reg;
    logic              clear_reg;
    logic [SPD_W-1:0]  cv_reg;

    logic              clear;
    logic              dact_eff;
    logic [TIME_W-1:0] st_eff;
    logic [SPD_W-1:0]  ss_eff;
    logic              trig;
    logic [TIME_W-1:0] cur_e;
    logic [DUR_W-1:0]  cur_d;
    logic [SPD_W-1:0]  cur_a;
    logic [SPD_W-1:0]  cur_b;
    logic              end_hit;
    logic              is_run;
    curve_req_t        req;
    logic              curve_start;
    logic              curve_done;
    logic [SPD_W-1:0]  curve_result;
    logic              out_free;

    sssp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // entering running drops the deceleration latch before this tick's update
    assign is_run   = mode_reg == MODE_RUN;
    assign clear    = is_run && !was_run_reg;
    assign dact_eff = dact_reg && !clear;
    assign st_eff   = clear ? '0 : dstart_time_reg;
    assign ss_eff   = clear ? '0 : dstart_speed_reg;
    assign trig     = left_reg && !prog_reg[PROG_W-1]
                   && (prog_reg[TRIG_W-1:0] >= cfg.decel_trigger_count);

    assign cur_e   = dact_eff ? (now_reg - st_eff) : run_el_reg;
    assign cur_d   = dact_eff ? cfg.decel_time_ms : cfg.accel_time_ms;
    assign cur_a   = dact_eff ? ss_eff : cfg.start_speed;
    assign cur_b   = dact_eff ? cfg.finish_speed : cfg.cruise_speed;
    assign end_hit = cur_e >= TIME_W'(cur_d);

    assign req.a = cur_a;
    assign req.b = cur_b;
    assign req.e = cur_e[DUR_W-1:0];
    assign req.d = cur_d;

    assign curve_start = (state_reg == T_DECIDE) && is_run && !end_hit;

    sssp_curve u_curve (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (curve_start),
        .req    (req),
        .done   (curve_done),
        .result (curve_result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = state_reg == T_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-SPD_W-2){1'b0}}, stage_reg, speed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            dact_reg         <= 1'b0;
            dstart_time_reg  <= '0;
            dstart_speed_reg <= '0;
            speed_reg        <= '0;
            stage_reg        <= STAGE_IDLE;
            was_run_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (m_tready && state_reg != T_COMMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= T_DECIDE;
                    end
                end
                T_DECIDE:
                begin
                    state_reg <= curve_start ? T_CURVE : T_COMMIT;
                end
                T_CURVE:
                begin
                    if (curve_done)
                    begin
                        state_reg <= T_COMMIT;
                    end
                end
                T_COMMIT:
                begin
                    if (out_free)
                    begin
                        state_reg     <= T_IDLE;
                        out_valid_reg <= 1'b1;
                        was_run_reg   <= is_run;
                        unique case (mode_reg)
                            MODE_RUN:
                            begin
                                if (accel_reg && trig_reg)
                                begin
                                    // latch tick: decel curve sits at elapsed zero
                                    dact_reg         <= 1'b1;
                                    dstart_time_reg  <= now_reg;
                                    dstart_speed_reg <= cv_reg;
                                    stage_reg        <= STAGE_STOPPING;
                                    speed_reg        <= (cfg.decel_time_ms == '0)
                                                        ? cfg.finish_speed : cv_reg;
                                end
                                else
                                begin
                                    if (clear_reg)
                                    begin
                                        dact_reg         <= 1'b0;
                                        dstart_time_reg  <= '0;
                                        dstart_speed_reg <= '0;
                                    end
                                    speed_reg <= cv_reg;
                                    if (accel_reg)
                                    begin
                                        stage_reg <= (run_el_reg < TIME_W'(cfg.accel_time_ms))
                                                     ? STAGE_RAMP : STAGE_CRUISE;
                                    end
                                    else
                                    begin
                                        stage_reg <= STAGE_STOPPING;
                                    end
                                end
                            end
                            MODE_STOP:
                            begin
                                stage_reg <= STAGE_STOPPING;
                            end
                            MODE_OFF:
                            begin
                                stage_reg <= STAGE_IDLE;
                                speed_reg <= '0;
                                dact_reg  <= 1'b0;
                            end
                            MODE_HOLD: ;
                            default: ;
                        endcase
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && s_tvalid)
        begin
            mode_reg   <= s_tuser;
            now_reg    <= s_tdata[31:0];
            run_el_reg <= s_tdata[63:32];
            left_reg   <= s_tdata[64];
            prog_reg   <= s_tdata[96:65];
        end
        if (state_reg == T_DECIDE)
        begin
            accel_reg <= !dact_eff;
            trig_reg  <= trig;
            clear_reg <= clear;
            if (end_hit)
            begin
                cv_reg <= cur_b;
            end
        end
        if (state_reg == T_CURVE && curve_done)
        begin
            cv_reg <= curve_result;
        end
    end

endmodule
`default_nettype wire
